>>> sv/crc32c_pkg.sv
// shared types, constants and elaboration-time helpers for the crc-32c word engine
// no dependencies; used by crc32c_lane, crc32c_shift and crc32c_wide_update
package crc32c_pkg;

	localparam int unsigned WORD_BYTES = 8;
	localparam int unsigned CRC_W      = 32;

	localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INVERT = 32'hFFFF_FFFF;

	typedef logic [31:0] crc_t;
	typedef logic [3:0]  byte_cnt_t;

	// advance a reflected crc register over nbytes zero bytes
	// only called with constant arguments to build xor matrices
	function automatic crc_t crc_zero_bytes(crc_t crc_in, int unsigned nbytes);
		crc_t r;
		r = crc_in;
		for (int unsigned b = 0; b < 8 * WORD_BYTES; b++) begin
			if (b < 8 * nbytes) begin
				r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
			end
		end
		return r;
	endfunction

endpackage

>>> sv/crc32c_lane.sv
// one byte lane: crc contribution of the byte at a fixed slot of an eight-byte word
// depends on crc32c_pkg for crc_zero_bytes and types
module crc32c_lane #(
	parameter int unsigned POS = 0
) (
	input  logic [7:0]        lane_byte,
	output crc32c_pkg::crc_t  lane_crc
);

	crc32c_pkg::crc_t terms [8];

	// each data bit maps to a fixed column: fold of that bit, then the zero bytes after it
	for (genvar i = 0; i < 8; i++) begin : g_col
		localparam crc32c_pkg::crc_t COL =
			crc32c_pkg::crc_zero_bytes(crc32c_pkg::crc_t'(1) << i,
				crc32c_pkg::WORD_BYTES - POS);
		assign terms[i] = lane_byte[i] ? COL : '0;
	end

	always_comb begin
		lane_crc = '0;
		for (int i = 0; i < 8; i++) begin
			lane_crc = lane_crc ^ terms[i];
		end
	end

endmodule

>>> sv/crc32c_shift.sv
// advances the running crc register over 0 to 8 zero bytes in one step
// depends on crc32c_pkg for crc_zero_bytes and types
module crc32c_shift (
	input  crc32c_pkg::crc_t      crc_in,
	input  crc32c_pkg::byte_cnt_t nbytes,
	output crc32c_pkg::crc_t      crc_out
);

	localparam int unsigned NMAT = crc32c_pkg::WORD_BYTES + 1;

	crc32c_pkg::crc_t terms [NMAT][crc32c_pkg::CRC_W];
	crc32c_pkg::crc_t shifted [NMAT];

	for (genvar n = 0; n < NMAT; n++) begin : g_mat
		for (genvar j = 0; j < crc32c_pkg::CRC_W; j++) begin : g_col
			localparam crc32c_pkg::crc_t COL =
				crc32c_pkg::crc_zero_bytes(crc32c_pkg::crc_t'(1) << j, n);
			assign terms[n][j] = crc_in[j] ? COL : '0;
		end
	end

	always_comb begin
		for (int n = 0; n < NMAT; n++) begin
			shifted[n] = '0;
			for (int j = 0; j < crc32c_pkg::CRC_W; j++) begin
				shifted[n] = shifted[n] ^ terms[n][j];
			end
		end
	end

	// nbytes is already saturated to the word size upstream
	always_comb begin
		if (nbytes < crc32c_pkg::byte_cnt_t'(NMAT)) begin
			crc_out = shifted[nbytes];
		end else begin
			crc_out = shifted[NMAT-1];
		end
	end

endmodule

>>> sv/crc32c_wide_update.sv
// crc-32c (castagnoli, reflected polynomial 0x82f63b78) over a byte stream fed as
// 64-bit little-endian words of 1 to 8 valid low-order bytes. a beat with first set
// starts from the inverted initial_crc, every beat folds its bytes into the running
// register, and a beat with last set returns the register inverted as crc_value.
// throughput is one input beat per clock unless a last beat finds the result slot
// full; crc_value is registered after stage 1. the rate is set by feedback of the
// running register through the zero-byte shift matrix and one xor with the lane crc.
// a byte count of zero folds nothing; counts above eight act as eight.
// depends on crc32c_pkg, crc32c_lane and crc32c_shift
module crc32c_wide_update (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        first,
	input  logic        last,
	input  logic [31:0] initial_crc,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] crc_value
);

	// input side: saturate the count and right-align the valid bytes to the top of
	// the word, so leading zero bytes (which leave a zero register untouched) fill
	// the low slots and a fixed eight-lane fold gives the data-only crc
	crc32c_pkg::byte_cnt_t nsat;
	crc32c_pkg::byte_cnt_t pad;
	logic [6:0]            shamt;
	logic [63:0]           aligned;
	crc32c_pkg::crc_t      lane_crc [crc32c_pkg::WORD_BYTES];
	crc32c_pkg::crc_t      data_crc;

	always_comb begin
		if (byte_count > crc32c_pkg::byte_cnt_t'(crc32c_pkg::WORD_BYTES)) begin
			nsat = crc32c_pkg::byte_cnt_t'(crc32c_pkg::WORD_BYTES);
		end else begin
			nsat = byte_count;
		end
		pad     = crc32c_pkg::byte_cnt_t'(crc32c_pkg::WORD_BYTES) - nsat;
		shamt   = {pad, 3'b000};
		aligned = data_word << shamt;
	end

	// parallel byte lanes, each a fixed xor matrix
	for (genvar p = 0; p < crc32c_pkg::WORD_BYTES; p++) begin : g_lane
		crc32c_lane #(
			.POS (p)
		) u_lane (
			.lane_byte (aligned[8*p +: 8]),
			.lane_crc  (lane_crc[p])
		);
	end

	// merge: xor of all lanes
	always_comb begin
		data_crc = '0;
		for (int p = 0; p < crc32c_pkg::WORD_BYTES; p++) begin
			data_crc = data_crc ^ lane_crc[p];
		end
	end

	// stage 1 registers
	logic                  valid_s1;
	crc32c_pkg::crc_t      data_crc_s1;
	crc32c_pkg::byte_cnt_t nbytes_s1;
	logic                  first_s1;
	logic                  last_s1;
	crc32c_pkg::crc_t      init_s1;

	// result register
	logic                  out_valid_q;
	crc32c_pkg::crc_t      crc_q;
	crc32c_pkg::crc_t      running_q;

	logic                  out_free;
	logic                  adv_s1;
	logic                  in_take;

	// a stage-1 beat without last never waits; one with last needs a free result slot
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_crc_s1 <= data_crc;
			nbytes_s1   <= nsat;
			first_s1    <= first;
			last_s1     <= last;
			init_s1     <= initial_crc;
		end
	end

	// stage 2: running register update, start value chosen by first
	crc32c_pkg::crc_t start_crc;
	crc32c_pkg::crc_t shifted_crc;
	crc32c_pkg::crc_t next_crc;

	assign start_crc = first_s1 ? (init_s1 ^ crc32c_pkg::CRC_INVERT) : running_q;

	crc32c_shift u_shift (
		.crc_in  (start_crc),
		.nbytes  (nbytes_s1),
		.crc_out (shifted_crc)
	);

	assign next_crc = shifted_crc ^ data_crc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				running_q <= next_crc;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			crc_q <= next_crc ^ crc32c_pkg::CRC_INVERT;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_q;

endmodule

>>> tb/tb_crc32c_wide_update.sv
// self-checking testbench for crc32c_wide_update: directed corner beats, random messages,
// a long result-side hold-off and a tail with no idling, all checked against a local crc model
// depends on crc32c_pkg and crc32c_wide_update
module tb_crc32c_wide_update;

	localparam int unsigned CYCLE_LIMIT   = 200000; // watchdog, far above the slowest legal run
	localparam int unsigned HOLD_CYCLES   = 150;    // long result-side hold-off
	localparam int unsigned DRAIN_CYCLES  = 12;     // drain wait; the result is registered after stage 1
	localparam int unsigned RANDOM_ITEMS  = 500;
	localparam int unsigned MAX_REPORTS   = 10;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [63:0]           data_word   = '0;
	crc32c_pkg::byte_cnt_t byte_count  = '0;
	logic                  first       = 1'b0;
	logic                  last        = 1'b0;
	crc32c_pkg::crc_t      initial_crc = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	crc32c_pkg::crc_t      crc_value;

	// crc model state and the finished values still owed by the block
	crc32c_pkg::crc_t      msg_crc = '0;
	crc32c_pkg::crc_t      expected_crcs[$];

	int unsigned error_count   = 0;
	int unsigned items_sent    = 0;
	int unsigned cycle_count   = 0;
	int unsigned hold_requests = 0; // bumped by a test, served by the result sink
	bit          quiet         = 1'b0; // no idling on either side once set

	crc32c_wide_update DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_word  (data_word),
		.byte_count (byte_count),
		.first      (first),
		.last       (last),
		.initial_crc(initial_crc),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.crc_value  (crc_value)
	);

	always #1 clk = ~clk;

	// fold up to eight bytes of one word into a reflected castagnoli register,
	// lowest byte first; counts above eight act as eight, zero folds nothing
	function automatic crc32c_pkg::crc_t castagnoli_fold(crc32c_pkg::crc_t crc,
			logic [63:0] w, crc32c_pkg::byte_cnt_t n);
		int unsigned nbytes;
		nbytes = (n > 4'd8) ? 8 : n;
		for (int unsigned i = 0; i < nbytes; i++) begin
			crc ^= {24'd0, w[8*i +: 8]};
			for (int b = 0; b < 8; b++) begin
				crc = crc[0] ? ((crc >> 1) ^ crc32c_pkg::CRC_POLY) : (crc >> 1);
			end
		end
		return crc;
	endfunction

	task automatic report_error(input string what, input crc32c_pkg::crc_t want,
			input crc32c_pkg::crc_t got);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("ERROR @%0d: %s expected %08h got %08h", cycle_count, what, want, got);
		end
	endtask

	// offer one beat and hold it until taken; the model advances at the accepting edge
	task automatic send_beat(input logic [63:0] w, input crc32c_pkg::byte_cnt_t n,
			input logic f, input logic l, input crc32c_pkg::crc_t init);
		crc32c_pkg::crc_t start;
		in_valid    <= 1'b1;
		data_word   <= w;
		byte_count  <= n;
		first       <= f;
		last        <= l;
		initial_crc <= init;
		do @(posedge clk); while (in_stall);
		start   = f ? (init ^ crc32c_pkg::CRC_INVERT) : msg_crc;
		msg_crc = castagnoli_fold(start, w, n);
		if (l) begin
			expected_crcs.push_back(msg_crc ^ crc32c_pkg::CRC_INVERT);
		end
		items_sent++;
	endtask

	// random sender-side gap, skipped in the quiet tail
	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// drop valid after the last beat of a test so it is not taken twice
	task automatic stop_offering();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic crc32c_pkg::crc_t random_seed_crc();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return crc32c_pkg::CRC_INVERT;
			default: return $urandom;
		endcase
	endfunction

	// one message of nbeats beats; broken messages scramble the framing and byte counts
	task automatic send_message(input int unsigned nbeats, input bit broken);
		crc32c_pkg::crc_t      seed;
		crc32c_pkg::byte_cnt_t n;
		logic                  f;
		logic                  l;
		seed = random_seed_crc();
		for (int unsigned i = 0; i < nbeats; i++) begin
			if (broken) begin
				f = 1'($urandom_range(0, 1));
				l = 1'($urandom_range(0, 1));
				n = crc32c_pkg::byte_cnt_t'($urandom_range(0, 15));
			end else begin
				f = (i == 0);
				l = (i == nbeats - 1);
				// full words inside a message, a short tail, now and then an odd count
				if ($urandom_range(0, 9) == 0) n = crc32c_pkg::byte_cnt_t'($urandom_range(0, 15));
				else if (l) n = crc32c_pkg::byte_cnt_t'($urandom_range(1, 8));
				else n = 4'd8;
			end
			send_beat(random_word(), n, f, l, f ? seed : crc32c_pkg::crc_t'($urandom));
			maybe_gap();
		end
	endtask

	// a beat with no first right after reset folds into the cleared register
	task automatic test_after_reset();
		send_beat(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 1'b1, 32'hDEAD_BEEF);
		send_beat(64'h0000_0000_0000_0000, 4'd3, 1'b0, 1'b1, 32'h0000_0000);
		stop_offering();
	endtask

	// extremes of every field, short counts, oversize and zero counts, split messages
	task automatic test_corner_beats();
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b1, 32'h0000_0000);
		send_beat(64'h0000_0000_0000_0000, 4'd8, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_beat(64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 1'b1, 1'b1, 32'h5555_5555);
		send_beat(64'h5555_5555_5555_5555, 4'd8, 1'b1, 1'b1, 32'hAAAA_AAAA);
		// zero count still loads and emits
		send_beat(64'h1234_5678_9ABC_DEF0, 4'd0, 1'b1, 1'b1, 32'h1234_5678);
		// oversize counts behave as eight
		send_beat(64'hFEDC_BA98_7654_3210, 4'd9, 1'b1, 1'b1, 32'h0000_0000);
		send_beat(64'hFEDC_BA98_7654_3210, 4'd15, 1'b1, 1'b1, 32'h0000_0000);
		// the usual check string "123456789" over two beats
		send_beat(64'h3837_3635_3433_3231, 4'd8, 1'b1, 1'b0, 32'h0000_0000);
		send_beat(64'h0000_0000_0000_0039, 4'd1, 1'b0, 1'b1, 32'hFFFF_FFFF);
		// keep folding after last without a new first
		send_beat(64'h0000_0000_C0FF_EE00, 4'd4, 1'b0, 1'b1, 32'h0000_0000);
		// zero-count beat in the middle of a message
		send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b0, 32'h0000_0000);
		send_beat(64'h0000_0000_0000_00A5, 4'd1, 1'b0, 1'b1, 32'h0000_0000);
		// every short count on its own single-beat message
		for (int unsigned n = 1; n < 8; n++) begin
			send_beat(64'h8877_6655_4433_2211, crc32c_pkg::byte_cnt_t'(n), 1'b1, 1'b1,
				32'h8000_0001);
		end
		stop_offering();
	endtask

	// result side holds off for a long stretch while every beat wants a result,
	// so the block backs up and stalls its input
	task automatic test_result_backpressure();
		hold_requests++;
		for (int i = 0; i < 40; i++) begin
			send_beat(random_word(), crc32c_pkg::byte_cnt_t'($urandom_range(1, 8)),
				1'($urandom_range(0, 1)), 1'b1, crc32c_pkg::crc_t'($urandom));
		end
		stop_offering();
	endtask

	// mostly well-formed messages with random content, the rest scrambled
	task automatic test_random_messages();
		int unsigned stop_at;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 6) == 0) send_message($urandom_range(1, 4), 1'b1);
			else if ($urandom_range(0, 9) == 0) send_message($urandom_range(7, 16), 1'b0);
			else send_message($urandom_range(1, 6), 1'b0);
		end
		stop_offering();
	endtask

	// back-to-back traffic with no idling on either side
	task automatic test_quiet_tail();
		quiet = 1'b1;
		for (int i = 0; i < 12; i++) begin
			send_message($urandom_range(1, 5), 1'b0);
		end
		stop_offering();
	endtask

	// result sink: random stall bursts, plus the long hold-off counted here
	int unsigned holds_served = 0;
	int unsigned stall_left   = 0;
	always @(posedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			stall_left   = HOLD_CYCLES;
		end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 8);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// every accepted result beat against the oldest owed value
	always @(posedge clk) begin : result_check
		crc32c_pkg::crc_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_crcs.size() == 0) begin
				report_error("unexpected result beat", '0, crc_value);
			end else begin
				want = expected_crcs.pop_front();
				if (crc_value !== want) begin
					report_error("crc_value mismatch", want, crc_value);
				end
			end
		end
	end

	// watchdog
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : run_tests
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_corner_beats();
		test_result_backpressure();
		test_random_messages();
		test_quiet_tail();

		// let the pipeline drain, then anything still owed is missing
		while (expected_crcs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (expected_crcs.size() != 0) begin
			report_error("missing result beat", expected_crcs.pop_front(), '0);
		end

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/crc32c_pkg.sv
sv/crc32c_lane.sv
sv/crc32c_shift.sv
sv/crc32c_wide_update.sv
tb/tb_crc32c_wide_update.sv
